FILE: rtl/core/tlm_pkg.sv
// Shared types and constants for the two-line marquee display.
package tlm_pkg;

    localparam logic [7:0]  NUL_CODE      = 8'h00;
    localparam logic [7:0]  SPACE_CODE    = 8'h20;
    localparam int          TICK_W        = 17;
    localparam logic [16:0] TICK_MAX      = 17'h1FFFF;
    localparam int          PERIOD_W      = 16;
    localparam logic [15:0] PERIOD_RESET  = 16'd700;
    localparam logic        REQ_BYTE      = 1'b0;
    localparam logic        REQ_TICK      = 1'b1;
    localparam logic        ROW_TITLE     = 1'b0;
    localparam logic        ROW_MESSAGE   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic publish;
        logic bank;
    } t_disp_ctl;

endpackage

FILE: rtl/core/tlm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tlm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/tlm_rx.sv
// Receive side: gathers bytes into the back text bank and publishes by bank swap.
module tlm_rx
    import tlm_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_valid,
    input  logic [7:0]      i_byte,
    output logic            o_wr_en,
    output logic [AW+1:0]   o_wr_addr,
    output logic [7:0]      o_wr_data,
    output t_disp_ctl       o_disp,
    output logic [LEN_W-1:0] o_disp_len0,
    output logic [LEN_W-1:0] o_disp_len1
);

    logic             r_line, n_line;
    logic             r_bank, n_bank;
    logic [LEN_W-1:0] r_rlen0, n_rlen0;
    logic [LEN_W-1:0] r_rlen1, n_rlen1;
    logic [LEN_W-1:0] r_dlen0, n_dlen0;
    logic [LEN_W-1:0] r_dlen1, n_dlen1;
    logic [LEN_W-1:0] cur_len;
    logic             is_nul;
    logic             publish;

    assign cur_len = r_line ? r_rlen1 : r_rlen0;
    assign is_nul  = (i_byte == NUL_CODE);
    assign o_wr_en = i_byte_valid && !is_nul && (cur_len < LEN_W'(MAX_LEN));
    assign publish = i_byte_valid && is_nul && (r_line == ROW_MESSAGE);

    // back bank is the one not on display
    assign o_wr_addr = {~r_bank, r_line, cur_len[AW-1:0]};
    assign o_wr_data = i_byte;

    always_comb begin
        n_line  = r_line;
        n_bank  = r_bank;
        n_rlen0 = r_rlen0;
        n_rlen1 = r_rlen1;
        n_dlen0 = r_dlen0;
        n_dlen1 = r_dlen1;
        if (o_wr_en) begin
            if (r_line) begin
                n_rlen1 = r_rlen1 + LEN_W'(1);
            end else begin
                n_rlen0 = r_rlen0 + LEN_W'(1);
            end
        end else if (i_byte_valid && is_nul && (r_line == ROW_TITLE)) begin
            n_line = ROW_MESSAGE;
        end else if (publish) begin
            n_line  = ROW_TITLE;
            n_bank  = ~r_bank;
            n_dlen0 = r_rlen0;
            n_dlen1 = r_rlen1;
            n_rlen0 = '0;
            n_rlen1 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= ROW_TITLE;
            r_bank  <= 1'b0;
            r_rlen0 <= '0;
            r_rlen1 <= '0;
            r_dlen0 <= '0;
            r_dlen1 <= '0;
        end else begin
            r_line  <= n_line;
            r_bank  <= n_bank;
            r_rlen0 <= n_rlen0;
            r_rlen1 <= n_rlen1;
            r_dlen0 <= n_dlen0;
            r_dlen1 <= n_dlen1;
        end
    end

    assign o_disp.publish = publish;
    assign o_disp.bank    = r_bank;
    assign o_disp_len0    = r_dlen0;
    assign o_disp_len1    = r_dlen1;

endmodule

FILE: rtl/core/tlm_render.sv
// Refresh sequencer: tick timer, scroll offsets, text reads and output register.
module tlm_render
    import tlm_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int WIDTH   = 16,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  t_disp_ctl           i_disp,
    input  logic [LEN_W-1:0]    i_disp_len0,
    input  logic [LEN_W-1:0]    i_disp_len1,
    output logic                o_idle,
    output logic                o_rd_en,
    output logic [AW+1:0]       o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_row,
    output logic [3:0]          o_column,
    output logic [7:0]          o_char,
    output logic                o_last
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int IW = LEN_W + 1;

    t_state              r_state, n_state;
    logic [PERIOD_W-1:0] r_period;
    logic [TICK_W-1:0]   r_ticks, n_ticks, tick_inc;
    logic                r_row;
    logic [CW-1:0]       r_col;
    logic [LEN_W-1:0]    r_off0, r_off1;
    logic                r_in_text;
    logic                r_out_valid;
    logic                r_out_row;
    logic [3:0]          r_out_col;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    logic                start;
    logic                slot_free;
    logic                load;
    logic                line_end;
    logic [LEN_W-1:0]    sel_len, sel_off;
    logic                sel_long;
    logic [IW-1:0]       idx;
    logic [LEN_W-1:0]    off_next;

    assign tick_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + TICK_W'(1);
    assign start    = i_tick && (tick_inc > TICK_W'(r_period));
    assign n_ticks  = start ? '0 : (i_tick ? tick_inc : r_ticks);

    assign slot_free = !r_out_valid || i_ready;
    assign line_end  = (r_col == CW'(WIDTH - 1));

    assign sel_len  = r_row ? i_disp_len1 : i_disp_len0;
    assign sel_off  = r_row ? r_off1 : r_off0;
    assign sel_long = (32'(sel_len) > 32'(WIDTH));
    assign idx      = IW'(r_col) + (sel_long ? IW'(sel_off) : IW'(0));
    assign off_next = (32'(sel_off) == 32'(sel_len) - 32'(WIDTH)) ? '0
                    : sel_off + LEN_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    n_state = (line_end && r_row == ROW_MESSAGE) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_idle    = 1'b0;
        o_rd_en   = 1'b0;
        load      = 1'b0;
        case (r_state)
            ST_IDLE: o_idle  = 1'b1;
            ST_READ: o_rd_en = 1'b1;
            ST_LOAD: load    = slot_free;
            default: o_idle  = 1'b0;
        endcase
    end

    assign o_rd_addr = {i_disp.bank, r_row, idx[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= PERIOD_RESET;
            r_ticks     <= '0;
            r_row       <= ROW_TITLE;
            r_col       <= '0;
            r_off0      <= '0;
            r_off1      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ticks <= n_ticks;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (start) begin
                r_row <= ROW_TITLE;
                r_col <= '0;
            end else if (load) begin
                if (line_end) begin
                    r_row <= ROW_MESSAGE;
                    r_col <= '0;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_disp.publish) begin
                r_off0 <= '0;
                r_off1 <= '0;
            end else if (load && line_end && sel_long) begin
                if (r_row) begin
                    r_off1 <= off_next;
                end else begin
                    r_off0 <= off_next;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_in_text <= (idx < IW'(sel_len));
        end
        if (load) begin
            r_out_row  <= r_row;
            r_out_col  <= 4'(r_col);
            r_out_char <= r_in_text ? i_rd_data : SPACE_CODE;
            r_out_last <= line_end && (r_row == ROW_MESSAGE);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_row    = r_out_row;
    assign o_column = r_out_col;
    assign o_char   = r_out_char;
    assign o_last   = r_out_last;

endmodule

FILE: rtl/core/two_line_marquee_text_display_top.sv
// Top level of the two-line scrolling text marquee.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser=req_type, tdata[7:0]=rx_byte
//  m_axis    out  tvalid/tready          tdata=row,column,char_code; tlast=last
//  cfg       in   i_cfg_wr_en            i_cfg_wr_data=scroll_period
//
//  A byte or a tick that does not refresh leaves s_axis ready for the next item.
//  A refresh emits 2*WIDTH writes, each a text memory read followed by an output load.
//  s_axis_tready is low while a refresh runs; a stalled m_axis holds the sequencer.
//  Reset (synchronous, active low) empties both lines; text memory needs no clearing.
module two_line_marquee_text_display_top
    import tlm_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] row, [4:1] column, [12:5] char_code, [15:13] zero
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);

    logic             accept;
    logic             wr_en;
    logic [AW+1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW+1:0]    rd_addr;
    logic [7:0]       rd_data;
    t_disp_ctl        disp;
    logic [LEN_W-1:0] disp_len0, disp_len1;
    logic             idle;
    logic             out_row;
    logic [3:0]       out_col;
    logic [7:0]       out_char;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = idle;

    tlm_rx #(
        .MAX_LEN(MAX_LEN)
    ) u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_valid(accept && (s_axis_tuser == REQ_BYTE)),
        .i_byte      (s_axis_tdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_disp      (disp),
        .o_disp_len0 (disp_len0),
        .o_disp_len1 (disp_len1)
    );

    tlm_ram #(
        .DATA_W(8),
        .DEPTH (4 << AW)
    ) u_text_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    tlm_render #(
        .MAX_LEN(MAX_LEN),
        .WIDTH  (WIDTH)
    ) u_render (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (accept && (s_axis_tuser == REQ_TICK)),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_disp       (disp),
        .i_disp_len0  (disp_len0),
        .i_disp_len1  (disp_len1),
        .o_idle       (idle),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_row        (out_row),
        .o_column     (out_col),
        .o_char       (out_char),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_char, out_col, out_row};

endmodule

FILE: rtl/core/tlm_checker.sv
// Port-level assertions for the marquee top level, bound to it.
module tlm_checker
    import tlm_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[0] == ROW_MESSAGE && m_axis_tdata[4:1] == 4'(WIDTH - 1))
        else $error("last write not at end of message row");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a refresh");

    a_byte_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_BYTE && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("byte transaction produced output");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind two_line_marquee_text_display_top tlm_checker #(
    .WIDTH(WIDTH)
) u_tlm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

FILE: tb/testbench.sv
// Self-checking testbench for the two-line scrolling text marquee.
module testbench;
    import tlm_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int WIDTH          = 16;
    localparam int IDLE_SETTLE    = 8;
    localparam int DRAIN_CYCLES   = 50;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int TOTAL_ITEMS    = 310;
    localparam int POWER_ON_TICKS = 24;

    typedef struct packed {
        logic       row;
        logic [3:0] column;
        logic [7:0] char_code;
        logic       last;
    } char_write_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [0] row, [4:1] column, [12:5] char_code, [15:13] zero
    logic        m_axis_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    two_line_marquee_text_display_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // marquee state as seen by the testbench
    logic [7:0]  rx_text [2][MAX_LEN];
    int          rx_len [2];
    logic        rx_row;
    logic [7:0]  shown_text [2][MAX_LEN];
    int          shown_len [2];
    int          scroll_pos [2];
    logic [16:0] tick_count;
    logic [15:0] refresh_period;

    char_write_t pending_writes [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          item_count = 0;
    bit          src_steady = 1'b0;
    bit          sink_steady = 1'b0;
    int          hold_serial = 0;
    int          hold_length = 0;

    task automatic render_row(input logic row);
        char_write_t w;
        int          r;
        int          pos;
        r = row ? 1 : 0;
        for (int c = 0; c < WIDTH; c++) begin
            pos = (shown_len[r] > WIDTH) ? c + scroll_pos[r] : c;
            w.row = row;
            w.column = c[3:0];
            w.char_code = (pos < shown_len[r] && pos < MAX_LEN) ? shown_text[r][pos] : SPACE_CODE;
            w.last = (row == ROW_MESSAGE) && (c == WIDTH - 1);
            pending_writes.push_back(w);
        end
        if (shown_len[r] > WIDTH)
            scroll_pos[r] = (scroll_pos[r] + 1) % (shown_len[r] - WIDTH + 1);
    endtask

    task automatic predict_item(input logic kind, input logic [7:0] data);
        int r;
        r = rx_row ? 1 : 0;
        if (kind == REQ_TICK) begin
            if (tick_count < TICK_MAX)
                tick_count = tick_count + 1'b1;
            if (tick_count > {1'b0, refresh_period}) begin
                render_row(ROW_TITLE);
                render_row(ROW_MESSAGE);
                tick_count = '0;
            end
        end else if (data != NUL_CODE) begin
            if (rx_len[r] < MAX_LEN) begin
                rx_text[r][rx_len[r]] = data;
                rx_len[r]++;
            end
        end else if (rx_row == ROW_TITLE) begin
            rx_row = ROW_MESSAGE;
        end else begin
            shown_text = rx_text;
            shown_len = rx_len;
            scroll_pos[0] = 0;
            scroll_pos[1] = 0;
            rx_len[0] = 0;
            rx_len[1] = 0;
            rx_row = ROW_TITLE;
        end
    endtask

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_item(input logic kind, input logic [7:0] data);
        if (!src_steady) begin
            while ($urandom_range(99) < 27) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, data);
        item_count++;
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom_range(255)));
    endtask

    task automatic send_text(input int count, input int tick_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < tick_pct)
                send_tick();
            send_item(REQ_BYTE, 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_scroll_period(input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        refresh_period = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // reset period of 700: the first ticks after reset refresh nothing
    task automatic test_power_on_period();
        repeat (POWER_ON_TICKS) send_tick();
        if (pending_writes.size() != 0) begin
            error_count++;
            $display("refresh predicted before the reset period ran out");
        end
    endtask

    task automatic test_short_lines();
        wait_idle();
        set_scroll_period(16'd0);
        send_item(REQ_BYTE, 8'h01);
        send_item(REQ_BYTE, 8'hFF);
        send_item(REQ_BYTE, 8'h41);
        send_item(REQ_BYTE, NUL_CODE);
        send_item(REQ_BYTE, 8'h7F);
        send_item(REQ_BYTE, 8'h80);
        send_tick();
        send_item(REQ_BYTE, NUL_CODE);
        send_item(REQ_TICK, 8'h00);
        send_item(REQ_TICK, 8'hFF);
    endtask

    // title overflows MAX_LEN, message is one column too wide and wraps every other refresh
    task automatic test_long_lines();
        for (int i = 0; i < MAX_LEN + 3; i++)
            send_item(REQ_BYTE, 8'(8'h21 + i));
        send_item(REQ_BYTE, NUL_CODE);
        for (int i = 0; i < WIDTH + 1; i++)
            send_item(REQ_BYTE, 8'(8'h61 + i));
        send_item(REQ_BYTE, NUL_CODE);
        repeat (4) send_tick();
    endtask

    task automatic test_unit_period();
        wait_idle();
        set_scroll_period(16'd1);
        repeat (5) send_tick();
    endtask

    // largest period: a burst of ticks refreshes nothing
    task automatic test_long_period();
        wait_idle();
        set_scroll_period(16'hFFFF);
        src_steady = 1'b1;
        sink_steady = 1'b1;
        repeat (16) send_tick();
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_output_stall();
        wait_idle();
        set_scroll_period(16'd0);
        hold_length = 300;
        hold_serial++;
        src_steady = 1'b1;
        repeat (8) send_tick();
        src_steady = 1'b0;
    endtask

    function automatic int pick_len();
        if ($urandom_range(99) < 80)
            return $urandom_range(0, 20);
        return $urandom_range(WIDTH + 1, MAX_LEN + 6);
    endfunction

    task automatic test_random_traffic();
        int          pick;
        int          round;
        logic [15:0] period;
        round = 0;
        while (item_count < TOTAL_ITEMS) begin
            wait_idle();
            src_steady = (round >= 1 && round < 4);
            sink_steady = src_steady;
            pick = $urandom_range(99);
            if (pick < 40)
                period = 16'($urandom_range(0, 3));
            else if (pick < 92)
                period = 16'($urandom_range(4, 12));
            else
                period = 16'($urandom_range(0, 65535));
            set_scroll_period(period);
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_text(pick_len(), 8);
                send_item(REQ_BYTE, NUL_CODE);
                send_text(pick_len(), 8);
                send_item(REQ_BYTE, NUL_CODE);
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (pick < 90) begin
                send_text(pick_len(), 8);
                send_item(REQ_BYTE, NUL_CODE);
                send_text($urandom_range(0, 8), 8);
                repeat ($urandom_range(1, 6)) send_tick();
            end else begin
                repeat ($urandom_range(1, 10))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            round++;
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_seen != hold_serial) begin
            hold_seen = hold_serial;
            hold_left = hold_length;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= sink_steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        char_write_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_writes.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transaction: tdata=%h tlast=%b", m_axis_tdata,
                             m_axis_tlast);
            end else begin
                want = pending_writes.pop_front();
                if (m_axis_tdata[0] !== want.row || m_axis_tdata[4:1] !== want.column ||
                    m_axis_tdata[12:5] !== want.char_code || m_axis_tdata[15:13] !== 3'b000 ||
                    m_axis_tlast !== want.last) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected row=%0d col=%0d char=%h last=%b, got %s",
                                 want.row, want.column, want.char_code, want.last,
                                 $sformatf("row=%0d col=%0d char=%h pad=%b last=%b",
                                           m_axis_tdata[0], m_axis_tdata[4:1],
                                           m_axis_tdata[12:5], m_axis_tdata[15:13],
                                           m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        rx_len = '{0, 0};
        rx_row = ROW_TITLE;
        shown_len = '{0, 0};
        scroll_pos = '{0, 0};
        tick_count = '0;
        refresh_period = PERIOD_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_period();
        test_short_lines();
        test_long_lines();
        test_unit_period();
        test_long_period();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
